// ----- src/cnc_pkg.sv -----
// Shared types and constants for the 3x3 convolution block.
// No dependencies; imported by the top level, cnc_ctrl, cnc_datapath and cnc_div.
`default_nettype none
package cnc_pkg;

    localparam int MAX_COLS    = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int LINE_DEPTH  = MAX_COLS + 2;
    localparam int POS_W       = 11;
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int ROW_W       = 3 * COEF_W;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int ACC_W       = 35;
    localparam int KSUM_W      = 20;
    localparam int DVS_W       = KSUM_W - 1;
    localparam int TAPS        = 9;
    localparam int TAP_W       = 4;
    localparam int CLAMP_MAX   = 255;

    // register map (index = byte address / 8)
    localparam logic [2:0] REG_KTOP  = 3'd0;
    localparam logic [2:0] REG_KMID  = 3'd1;
    localparam logic [2:0] REG_KBOT  = 3'd2;
    localparam logic [2:0] REG_NORM  = 3'd3;
    localparam logic [2:0] REG_COLS  = 3'd4;
    localparam logic [2:0] REG_ROWS  = 3'd5;

    typedef struct packed {
        logic               capture;
        logic               shift;
        logic               mac_clear;
        logic               mac_mul;
        logic               mac_add;
        logic [TAP_W-1:0]   tap_sel;
        logic               div_start;
        logic               load_out;
    } cnc_cmd_t;

    typedef struct packed {
        logic emit;
        logic need_div;
        logic div_busy;
        logic out_busy;
    } cnc_status_t;

endpackage
`default_nettype wire

// ----- src/conv3x3_normalize_clamp.sv -----
// Top level: 3x3 convolution with optional normalize and clamp.
// Depends on cnc_pkg, cnc_ctrl, cnc_datapath (which holds cnc_div).
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid/tready             tdata[15:0] sample
//  m_axis    out  tvalid/tready             tdata[34:0] filtered, tlast last_of_frame
//  apb       in   psel/penable/pwrite       paddr[5:0], pwdata/prdata 64b, 8 bytes/reg
//
// Steps: an input transaction that yields no result takes accept and window
// shift; one with a result takes accept, window shift, 10 MAC steps on one
// shared 16x16 multiplier, post and output load, plus a divide step with
// normalize on and a nonzero kernel sum (bit-serial divider, one quotient
// bit a cycle).
// Reset clears the window, positions and handshake state; line stores are not
// cleared. The finished result sits in an output register, so the next input
// transaction is taken while it waits; a stalled output only holds the next
// result in its final step.
`default_nettype none
module conv3x3_normalize_clamp
    import cnc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [34:0] filtered, rest zero
    output logic             m_axis_tlast,   // last_of_frame
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    logic [ROW_W-1:0] ktop_reg, kmid_reg, kbot_reg;
    logic             norm_reg;
    logic [POS_W-1:0] cols_reg, rows_reg;
    logic [POS_W-1:0] cols_eff, rows_eff;
    logic [2:0]       reg_idx;
    logic             wr_en;
    cnc_cmd_t         cmd;
    cnc_status_t      status;
    logic [ACC_W-1:0] filtered;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ktop_reg <= '0;
            kmid_reg <= '0;
            kbot_reg <= '0;
            norm_reg <= 1'b0;
            cols_reg <= POS_W'(MAX_COLS);
            rows_reg <= POS_W'(MAX_ROWS);
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_KTOP: ktop_reg <= pwdata[ROW_W-1:0];
                REG_KMID: kmid_reg <= pwdata[ROW_W-1:0];
                REG_KBOT: kbot_reg <= pwdata[ROW_W-1:0];
                REG_NORM: norm_reg <= pwdata[0];
                REG_COLS: cols_reg <= pwdata[POS_W-1:0];
                REG_ROWS: rows_reg <= pwdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_KTOP: prdata = 64'(ktop_reg);
            REG_KMID: prdata = 64'(kmid_reg);
            REG_KBOT: prdata = 64'(kbot_reg);
            REG_NORM: prdata = 64'(norm_reg);
            REG_COLS: prdata = 64'(cols_reg);
            REG_ROWS: prdata = 64'(rows_reg);
            default:  prdata = '0;
        endcase
    end

    // zero acts as one, oversize saturates
    always_comb
    begin
        if (cols_reg == '0)
            cols_eff = POS_W'(1);
        else if (cols_reg > POS_W'(MAX_COLS))
            cols_eff = POS_W'(MAX_COLS);
        else
            cols_eff = cols_reg;
        if (rows_reg == '0)
            rows_eff = POS_W'(1);
        else if (rows_reg > POS_W'(MAX_ROWS))
            rows_eff = POS_W'(MAX_ROWS);
        else
            rows_eff = rows_reg;
    end

    cnc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cnc_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .k_top         (ktop_reg),
        .k_mid         (kmid_reg),
        .k_bot         (kbot_reg),
        .norm_en       (norm_reg),
        .cols          (cols_eff),
        .rows          (rows_eff),
        .sample        (s_axis_tdata),
        .filtered      (filtered),
        .last_of_frame (m_axis_tlast),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready)
    );

    assign m_axis_tdata = {5'b0, filtered};

endmodule
`default_nettype wire

// ----- src/cnc_div.sv -----
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on cnc_pkg for widths.
`default_nettype none
module cnc_div
    import cnc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [ACC_W-1:0]  dividend,
    input  wire logic [DVS_W-1:0]  divisor,
    output logic                   busy,
    output logic [ACC_W-1:0]       quotient
);

    localparam int CNT_W = $clog2(ACC_W + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [ACC_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W:0]    shifted;
    logic [DVS_W+1:0]  trial;

    assign shifted = {rem_reg, quo_reg[ACC_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, divisor};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next  = CNT_W'(ACC_W);
            busy_next = 1'b1;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (!trial[DVS_W+1])
            begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[ACC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DVS_W-1:0];
                quo_next = {quo_reg[ACC_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ----- src/cnc_datapath.sv -----
// Datapath: line stores, 3x3 window, shared MAC, divider, output register.
// Depends on cnc_pkg and cnc_div.
`default_nettype none
module cnc_datapath
    import cnc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cnc_cmd_t            cmd,
    output cnc_status_t              status,
    input  wire logic [ROW_W-1:0]    k_top,
    input  wire logic [ROW_W-1:0]    k_mid,
    input  wire logic [ROW_W-1:0]    k_bot,
    input  wire logic                norm_en,
    input  wire logic [POS_W-1:0]    cols,
    input  wire logic [POS_W-1:0]    rows,
    input  wire logic [SAMPLE_W-1:0] sample,
    output logic [ACC_W-1:0]         filtered,
    output logic                     last_of_frame,
    output logic                     out_valid,
    input  wire logic                out_ready
);

    logic [SAMPLE_W-1:0] upper_mem [LINE_DEPTH];
    logic [SAMPLE_W-1:0] lower_mem [LINE_DEPTH];

    logic [SAMPLE_W-1:0] up_rd_reg, lo_rd_reg, smp_reg;
    logic                col_ok_reg;
    logic [SAMPLE_W-1:0] win_reg [TAPS];
    logic [POS_W-1:0]    row_reg, col_reg;
    logic                last_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [KSUM_W-1:0] ksum_reg;
    logic [ACC_W-1:0]    out_data_reg;
    logic                out_last_reg;
    logic                out_valid_reg;

    logic                col_ok;
    logic [POS_W:0]      col_lim, row_lim;
    logic                col_end, row_end;
    logic signed [SAMPLE_W-1:0] tap_val;
    logic signed [COEF_W-1:0]   coef_val;
    logic [ACC_W-1:0]    acc_mag;
    logic [DVS_W-1:0]    ksum_mag;
    logic [ACC_W-1:0]    quo;
    logic                div_busy;
    logic [ACC_W-1:0]    result;

    assign col_ok  = ({1'b0, col_reg} < (POS_W+1)'(LINE_DEPTH));
    assign col_lim = {1'b0, cols} + 1'b1;
    assign row_lim = {1'b0, rows} + 1'b1;
    assign col_end = ({1'b0, col_reg} >= col_lim);
    assign row_end = ({1'b0, row_reg} >= row_lim);

    // line store reads at capture, writes back on the shift cycle
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            smp_reg    <= sample;
            col_ok_reg <= col_ok;
            if (col_ok)
            begin
                up_rd_reg <= upper_mem[col_reg[POS_W-1:0]];
                lo_rd_reg <= lower_mem[col_reg[POS_W-1:0]];
            end
            else
            begin
                up_rd_reg <= '0;
                lo_rd_reg <= '0;
            end
        end
        if (cmd.shift && col_ok_reg)
        begin
            upper_mem[col_reg] <= lo_rd_reg;
            lower_mem[col_reg] <= smp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                win_reg[i] <= '0;
            end
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.shift)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[3*i]   <= win_reg[3*i+1];
                    win_reg[3*i+1] <= win_reg[3*i+2];
                end
                win_reg[2] <= up_rd_reg;
                win_reg[5] <= lo_rd_reg;
                win_reg[8] <= smp_reg;
                if (col_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_end ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        case (cmd.tap_sel)
            4'd0:    coef_val = k_top[15:0];
            4'd1:    coef_val = k_top[31:16];
            4'd2:    coef_val = k_top[47:32];
            4'd3:    coef_val = k_mid[15:0];
            4'd4:    coef_val = k_mid[31:16];
            4'd5:    coef_val = k_mid[47:32];
            4'd6:    coef_val = k_bot[15:0];
            4'd7:    coef_val = k_bot[31:16];
            4'd8:    coef_val = k_bot[47:32];
            default: coef_val = '0;
        endcase
        if (cmd.tap_sel < TAP_W'(TAPS))
        begin
            tap_val = win_reg[cmd.tap_sel];
        end
        else
        begin
            tap_val = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            last_reg <= col_end && row_end;
        end
        if (cmd.mac_mul)
        begin
            prod_reg <= tap_val * coef_val;
        end
        if (cmd.mac_clear)
        begin
            acc_reg  <= '0;
            ksum_reg <= '0;
        end
        else
        begin
            if (cmd.mac_add)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            if (cmd.mac_mul)
            begin
                ksum_reg <= ksum_reg + KSUM_W'(coef_val);
            end
        end
        if (cmd.load_out)
        begin
            out_data_reg <= result;
            out_last_reg <= last_reg;
        end
    end

    assign acc_mag  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : acc_reg;
    assign ksum_mag = ksum_reg[KSUM_W-1] ? DVS_W'(-ksum_reg) : ksum_reg[DVS_W-1:0];

    cnc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (acc_mag),
        .divisor  (ksum_mag),
        .busy     (div_busy),
        .quotient (quo)
    );

    always_comb
    begin
        if (!norm_en)
        begin
            result = acc_reg;
        end
        else if (ksum_reg != '0)
        begin
            // negative quotient clamps to zero
            if (acc_reg[ACC_W-1] != ksum_reg[KSUM_W-1])
                result = '0;
            else if (quo > ACC_W'(CLAMP_MAX))
                result = ACC_W'(CLAMP_MAX);
            else
                result = quo;
        end
        else
        begin
            if (acc_reg[ACC_W-1])
                result = '0;
            else if (acc_reg > ACC_W'(CLAMP_MAX))
                result = ACC_W'(CLAMP_MAX);
            else
                result = acc_reg;
        end
    end

    assign status.emit     = (row_reg >= POS_W'(2)) && (col_reg >= POS_W'(2));
    assign status.need_div = norm_en && (ksum_reg != '0);
    assign status.div_busy = div_busy;
    assign status.out_busy = out_valid_reg && !out_ready;

    assign filtered      = out_data_reg;
    assign last_of_frame = out_last_reg;
    assign out_valid     = out_valid_reg;

endmodule
`default_nettype wire

// ----- src/cnc_ctrl.sv -----
// Sequencer for capture, window shift, MAC passes, divide and output load.
// Depends on cnc_pkg.
`default_nettype none
module cnc_ctrl
    import cnc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire cnc_status_t status,
    output cnc_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_MAC,
        ST_POST,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t           state_reg;
    logic [TAP_W-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                        state_reg <= ST_SHIFT;
                end
                ST_SHIFT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= status.emit ? ST_MAC : ST_IDLE;
                end
                ST_MAC:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == TAP_W'(TAPS))
                        state_reg <= ST_POST;
                end
                ST_POST:
                begin
                    state_reg <= status.need_div ? ST_DIV : ST_FIN;
                end
                ST_DIV:
                begin
                    if (!status.div_busy)
                        state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (!status.out_busy)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd           = '0;
        cmd.capture   = (state_reg == ST_IDLE) && in_valid;
        cmd.shift     = (state_reg == ST_SHIFT);
        cmd.mac_clear = (state_reg == ST_SHIFT);
        cmd.mac_mul   = (state_reg == ST_MAC) && (cnt_reg < TAP_W'(TAPS));
        cmd.mac_add   = (state_reg == ST_MAC) && (cnt_reg != '0);
        cmd.tap_sel   = cnt_reg;
        cmd.div_start = (state_reg == ST_POST) && status.need_div;
        cmd.load_out  = (state_reg == ST_FIN) && !status.out_busy;
    end

endmodule
`default_nettype wire

// ----- src/cnc_checker.sv -----
// Port-level checks for conv3x3_normalize_clamp, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module cnc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // one item in flight: no back-to-back input transactions
    a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // a new result is loaded only while input side is busy
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without work in progress");

endmodule

bind conv3x3_normalize_clamp cnc_checker u_cnc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
